// ===== rtl/adaptive_gain_audio_mixer_macros.svh =====
// ----------------------------------------------------------------------------
// Adaptive gain audio mixer assertion macros
// Shared wrappers for the concurrent checks in the mixer RTL.
// ----------------------------------------------------------------------------
`ifndef ADAPTIVE_GAIN_AUDIO_MIXER_MACROS_SVH
`define ADAPTIVE_GAIN_AUDIO_MIXER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define AGA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// An expression that must never be true outside reset.
`define AGA_NEVER(lbl, expr, msg) \
  `AGA_ASSERT(lbl, !(expr), msg)

`endif

// ===== rtl/aga_pkg.sv =====
// ----------------------------------------------------------------------------
// Adaptive gain audio mixer package
// Constants and the shared arithmetic unit's operation codes.
// ----------------------------------------------------------------------------
package aga_pkg;

  localparam int DEF_MAX_INPUTS  = 8;
  localparam int DEF_SAMPLE_BITS = 16;

  // Number of sample ports on the block.
  localparam int NUM_SOURCES = 8;

  // Configuration register.
  localparam int              CFG_W             = 4;
  localparam logic [CFG_W-1:0] INPUT_COUNT_RESET = 4'd2;

  // Gain is unsigned Q1.15.
  localparam int               GAIN_W        = 16;
  localparam int               GAIN_FRAC     = 15;
  localparam logic [GAIN_W-1:0] GAIN_ONE     = 16'h8000;
  localparam logic [GAIN_W-1:0] RECOVER_BIAS = 16'd15;
  localparam int               RECOVER_SHIFT = 4;

  // Attenuation search over k/16, k from 15 down to 1.
  localparam int              K_BITS = 4;
  localparam logic [K_BITS-1:0] K_TOP = 4'd15;
  localparam logic [K_BITS-1:0] K_LOW = 4'd1;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

endpackage

// ===== rtl/aga_alu.sv =====
// ----------------------------------------------------------------------------
// Adaptive gain audio mixer shared adder
// One add/subtract unit that the sequencer reuses for summing, multiplying
// by shift and add, and stepping the attenuation search.
// ----------------------------------------------------------------------------
module aga_alu import aga_pkg::*; #(
  parameter int W = 40
) (
  input  alu_op_t             op,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  output logic signed [W-1:0] y
);

  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_SUB: y = a - b;
      default: y = a + b;
    endcase
  end

endmodule

// ===== rtl/adaptive_gain_audio_mixer.sv =====
// ----------------------------------------------------------------------------
// Adaptive gain audio mixer
// Sums up to eight sources, scales the sum by an adaptive gain and saturates.
// ----------------------------------------------------------------------------
// One transaction on the input channel carries a sample from every source;
// the first input_count of them, capped at min(MAX_INPUTS, 8), are summed,
// scaled by the stored Q1.15 gain and returned as one output transaction.
// On clipping the output saturates, clipped is raised and the gain is set
// to the largest k/16 for which k/16 of the product stays in range, if any;
// after every sample the gain recovers toward 1.0. A single adder does all
// the arithmetic, so an item passes an accept step, one summing step per
// summed source plus one to leave the sum, one multiply step per gain bit up
// to its highest set bit (at most 16), a range check, up to 15 search steps
// when the sample clipped, and an update step that waits while the output
// still holds an untaken result. The block takes the next input while the
// previous result still waits on the output. Configuration writes are taken
// every cycle and must happen while idle.
`include "adaptive_gain_audio_mixer_macros.svh"

module adaptive_gain_audio_mixer import aga_pkg::*; #(
  parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_0,
  input  logic signed [SAMPLE_BITS-1:0] sample_1,
  input  logic signed [SAMPLE_BITS-1:0] sample_2,
  input  logic signed [SAMPLE_BITS-1:0] sample_3,
  input  logic signed [SAMPLE_BITS-1:0] sample_4,
  input  logic signed [SAMPLE_BITS-1:0] sample_5,
  input  logic signed [SAMPLE_BITS-1:0] sample_6,
  input  logic signed [SAMPLE_BITS-1:0] sample_7,
  input  logic                          last_in_block,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] mixed_sample,
  output logic                          clipped,
  output logic                          block_end
);

  localparam int LIM  = (MAX_INPUTS < NUM_SOURCES) ? MAX_INPUTS : NUM_SOURCES;
  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_INPUTS);
  localparam int P_W   = SUM_W + GAIN_W;
  localparam int KP_W  = P_W + K_BITS;

  // Full scale of the product and sixteen times it, for the k search.
  localparam logic signed [KP_W-1:0] FULL =
    {{(KP_W-1){1'b0}}, 1'b1} << (SAMPLE_BITS - 1 + GAIN_FRAC);
  localparam logic signed [KP_W-1:0] FULL16 = FULL << K_BITS;

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_MUL,
    S_CHECK,
    S_KSRCH,
    S_RECOV
  } state_t;

  state_t                       state;
  logic [CFG_W-1:0]             input_count;
  logic [CFG_W-1:0]             cnt;
  logic signed [SAMPLE_BITS-1:0] smp [NUM_SOURCES];
  logic                         last;
  logic signed [SUM_W-1:0]      acc;
  logic signed [P_W-1:0]        msum;
  logic signed [P_W-1:0]        prod;
  logic [GAIN_W-1:0]            gshift;
  logic [GAIN_W-1:0]            gain;
  logic signed [KP_W-1:0]       kp;
  logic [K_BITS-1:0]            k;
  logic                         ovf;
  logic                         unf;
  logic signed [SAMPLE_BITS-1:0] mix_res;

  logic [CFG_W-1:0]             n_eff;
  alu_op_t                      alu_op;
  logic signed [KP_W-1:0]       alu_a;
  logic signed [KP_W-1:0]       alu_b;
  logic signed [KP_W-1:0]       alu_y;
  logic                         ov_now;
  logic                         un_now;
  logic                         fit;
  logic signed [SAMPLE_BITS-1:0] res_lin;
  logic [GAIN_W-1:0]            gain_step;
  logic [GAIN_W-1:0]            gain_next;
  logic                         out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  assign n_eff = (input_count > CFG_W'(LIM)) ? CFG_W'(LIM) : input_count;

  assign ov_now  = KP_W'(prod) >= FULL;
  assign un_now  = KP_W'(prod) <= -FULL;
  assign fit     = ovf ? (kp < FULL16) : (kp > -FULL16);
  assign res_lin = SAMPLE_BITS'(prod >>> GAIN_FRAC);

  assign gain_step = GAIN_W'({k, {(GAIN_FRAC-K_BITS){1'b0}}});
  assign gain_next = gain + ((GAIN_ONE - gain + RECOVER_BIAS) >> RECOVER_SHIFT);

  // Operand selection for the shared adder.
  always_comb begin
    alu_op = ALU_ADD;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      S_SUM: begin
        alu_a = KP_W'(acc);
        alu_b = KP_W'(smp[0]);
      end
      S_MUL: begin
        alu_a = KP_W'(prod);
        alu_b = gshift[0] ? KP_W'(msum) : '0;
      end
      S_CHECK: begin
        // 15 * P formed as 16 * P - P.
        alu_op = ALU_SUB;
        alu_a  = KP_W'(prod) <<< K_BITS;
        alu_b  = KP_W'(prod);
      end
      S_KSRCH: begin
        alu_op = ALU_SUB;
        alu_a  = kp;
        alu_b  = KP_W'(prod);
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  aga_alu #(
    .W (KP_W)
  ) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      input_count <= INPUT_COUNT_RESET;
      gain        <= GAIN_ONE;
      cnt         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        input_count <= cfg_data;
      end
      // A new result may load in the same cycle the held one is taken.
      if (state == S_RECOV && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            smp[0] <= sample_0;
            smp[1] <= sample_1;
            smp[2] <= sample_2;
            smp[3] <= sample_3;
            smp[4] <= sample_4;
            smp[5] <= sample_5;
            smp[6] <= sample_6;
            smp[7] <= sample_7;
            last   <= last_in_block;
            cnt    <= n_eff;
            acc    <= '0;
            state  <= S_SUM;
          end
        end
        S_SUM: begin
          if (cnt == '0) begin
            msum   <= P_W'(acc);
            prod   <= '0;
            gshift <= gain;
            state  <= S_MUL;
          end else begin
            acc <= SUM_W'(alu_y);
            for (int i = 0; i < NUM_SOURCES - 1; i++) begin
              smp[i] <= smp[i+1];
            end
            cnt <= cnt - 1'b1;
          end
        end
        S_MUL: begin
          // Shift-and-add multiply, least significant gain bit first.
          prod   <= P_W'(alu_y);
          msum   <= msum <<< 1;
          gshift <= gshift >> 1;
          if (gshift[GAIN_W-1:1] == '0) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          ovf <= ov_now;
          unf <= un_now;
          if (ov_now || un_now) begin
            kp      <= alu_y;
            k       <= K_TOP;
            mix_res <= ov_now ? SMAX : SMIN;
            state   <= S_KSRCH;
          end else begin
            mix_res <= res_lin;
            state   <= S_RECOV;
          end
        end
        S_KSRCH: begin
          if (fit) begin
            gain  <= gain_step;
            state <= S_RECOV;
          end else if (k == K_LOW) begin
            state <= S_RECOV;
          end else begin
            kp <= alu_y;
            k  <= k - 1'b1;
          end
        end
        S_RECOV: begin
          if (out_free) begin
            gain         <= gain_next;
            mixed_sample <= mix_res;
            clipped      <= ovf || unf;
            block_end    <= last;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `AGA_ASSERT(a_gain_range, (gain != '0) && (gain <= GAIN_ONE), "gain left 1..1.0")
  `AGA_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted while busy")
  `AGA_ASSERT(a_clip_saturates, (out_valid && clipped) |-> (mixed_sample == SMAX || mixed_sample == SMIN), "clipped output not saturated")
  `AGA_NEVER(a_cnt_limit, cnt > CFG_W'(LIM), "source count above limit")

endmodule
